>>> src/dhv_pkg.sv
// dhv_pkg: shared constants for the DDS header validator.
// Field widths, word offsets, fixed header values and size limits.
// No dependencies; compile first.
package dhv_pkg;

    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 27;
    localparam int POS_W      = 6;
    localparam int WORD_COUNT = 37;

    // Default limits for the top-level parameters
    localparam int DEF_MAX_DIMENSION  = 4096;
    localparam int DEF_MAX_MIP_LEVELS = 13;

    // Header word offsets (in words)
    localparam logic [POS_W-1:0] POS_MAGIC     = 6'd0;
    localparam logic [POS_W-1:0] POS_SIZE      = 6'd1;
    localparam logic [POS_W-1:0] POS_FLAGS     = 6'd2;
    localparam logic [POS_W-1:0] POS_HEIGHT    = 6'd3;
    localparam logic [POS_W-1:0] POS_WIDTH     = 6'd4;
    localparam logic [POS_W-1:0] POS_PITCH     = 6'd5;
    localparam logic [POS_W-1:0] POS_MIPCOUNT  = 6'd7;
    localparam logic [POS_W-1:0] POS_PF_SIZE   = 6'd19;
    localparam logic [POS_W-1:0] POS_PF_FLAGS  = 6'd20;
    localparam logic [POS_W-1:0] POS_FOURCC    = 6'd21;
    localparam logic [POS_W-1:0] POS_CAPS      = 6'd27;
    localparam logic [POS_W-1:0] POS_DXGI_FMT  = 6'd32;
    localparam logic [POS_W-1:0] POS_RES_DIM   = 6'd33;
    localparam logic [POS_W-1:0] POS_ARRAY_SZ  = 6'd35;
    localparam logic [POS_W-1:0] POS_LAST      = 6'd36;
    localparam logic [POS_W-1:0] POS_DONE      = 6'd37;

    // Fixed header values
    localparam logic [WORD_W-1:0] DDS_MAGIC    = 32'h2053_4444;
    localparam logic [WORD_W-1:0] DX10_TAG     = 32'h3031_5844;
    localparam logic [WORD_W-1:0] HDR_SIZE     = 32'd124;
    localparam logic [WORD_W-1:0] FLAGS_BASE   = 32'h0000_100F;
    localparam logic [WORD_W-1:0] FLAGS_MIPMAP = 32'h0002_0000;
    localparam logic [WORD_W-1:0] CAPS_BASE    = 32'h0000_1000;
    localparam logic [WORD_W-1:0] CAPS_MIPMAP  = 32'h0040_0008;
    localparam logic [WORD_W-1:0] PF_SIZE      = 32'd32;
    localparam logic [WORD_W-1:0] PF_FLAGS     = 32'd4;
    localparam logic [WORD_W-1:0] DXGI_FMT     = 32'd28;
    localparam logic [WORD_W-1:0] RES_DIM      = 32'd3;
    localparam logic [WORD_W-1:0] ARRAY_SZ     = 32'd1;

    // File size limits
    localparam int HEADER_BYTES = 148;
    localparam logic [SIZE_W-1:0] MIN_FILE = 27'd152;
    localparam logic [SIZE_W-1:0] MAX_FILE = 27'd67108864;

endpackage

>>> src/dhv_if.sv
// dhv_if: valid/ready channels of the DDS header validator.
// Header word input channel and verdict output channel.
// Depends on dhv_pkg.
interface dhv_in_if import dhv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] header_word;
    logic [SIZE_W-1:0] total_bytes;
    logic              first_word;

    modport source (output valid, header_word, total_bytes, first_word, input ready);
    modport sink   (input valid, header_word, total_bytes, first_word, output ready);
endinterface

interface dhv_out_if ();
    logic valid;
    logic ready;
    logic header_valid;

    modport source (output valid, header_valid, input ready);
    modport sink   (input valid, header_valid, output ready);
endinterface

>>> src/dds_header_validator_core.sv
// Intake: one header word per cycle while the job queue is not full; a new header
// can come in while earlier ones are still summed. A header that passes the field
// checks gets its verdict once its L mip levels are summed, one level per cycle
// through the shared multiplier; one that already failed skips the sum.
// Reset: rst_n is asynchronous, active low; it clears position, checks and queue.
//
// dds_header_validator_core: top level; depends on dhv_pkg, dhv_if, dhv_front,
// dhv_queue and dhv_back.
module dds_header_validator_core import dhv_pkg::*; #(
    parameter int MAX_DIMENSION  = DEF_MAX_DIMENSION,
    parameter int MAX_MIP_LEVELS = DEF_MAX_MIP_LEVELS
) (
    input  logic      clk,
    input  logic      rst_n,
    dhv_in_if.sink    hdr,
    dhv_out_if.source result
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int LVL_W = $clog2(MAX_MIP_LEVELS + 1);
    localparam int JOB_W = 1 + SIZE_W + LVL_W + 2 * DIM_W;

    // Job handoff: front pushes a finished header, back pops it
    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_out;
    logic             job_empty;

    // Front half: check each word as it arrives, track per-header state
    dhv_front #(
        .MAX_DIMENSION  (MAX_DIMENSION),
        .MAX_MIP_LEVELS (MAX_MIP_LEVELS),
        .DIM_W          (DIM_W),
        .LVL_W          (LVL_W),
        .JOB_W          (JOB_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr      (hdr),
        .job_push (job_push),
        .job_data (job_in),
        .job_full (job_full)
    );

    // Hold up to two finished headers so intake can go on while the sum runs
    dhv_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    // Back half: sum the mip chain and compare against the file size
    dhv_back #(
        .MAX_DIMENSION  (MAX_DIMENSION),
        .MAX_MIP_LEVELS (MAX_MIP_LEVELS),
        .DIM_W          (DIM_W),
        .LVL_W          (LVL_W),
        .JOB_W          (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .result    (result)
    );

endmodule

>>> src/dhv_front.sv
// dhv_front: per-word header checks, one word per cycle while the job queue has room.
// Pushes one job per completed header into the job queue.
// Depends on dhv_pkg and dhv_if.
module dhv_front import dhv_pkg::*; #(
    parameter int MAX_DIMENSION  = DEF_MAX_DIMENSION,
    parameter int MAX_MIP_LEVELS = DEF_MAX_MIP_LEVELS,
    parameter int DIM_W          = $clog2(MAX_DIMENSION + 1),
    parameter int LVL_W          = $clog2(MAX_MIP_LEVELS + 1),
    parameter int JOB_W          = 1 + SIZE_W + LVL_W + 2 * DIM_W
) (
    input  logic             clk,
    input  logic             rst_n,
    dhv_in_if.sink           hdr,
    output logic             job_push,
    output logic [JOB_W-1:0] job_data,
    input  logic             job_full
);

    localparam logic [DIM_W-1:0]  DIM_MAX  = DIM_W'(MAX_DIMENSION);
    localparam logic [LVL_W-1:0]  LVL_MAX  = LVL_W'(MAX_MIP_LEVELS);
    localparam logic [WORD_W-1:0] DIM_LIM  = WORD_W'(MAX_DIMENSION);
    localparam logic [WORD_W-1:0] LVL_LIM  = WORD_W'(MAX_MIP_LEVELS);

    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [SIZE_W-1:0] size_reg,     size_next;
    logic [DIM_W-1:0]  width_reg,    width_next;
    logic [DIM_W-1:0]  height_reg,   height_next;
    logic [LVL_W-1:0]  levels_reg,   levels_next;
    logic [WORD_W-1:0] flags_reg,    flags_next;
    logic              mismatch_reg, mismatch_next;

    logic              accept;
    logic              first;
    logic [POS_W-1:0]  eff_pos;
    logic              active;
    logic              word_ok;
    logic [WORD_W-1:0] word;
    logic              dim_range_ok;
    logic [DIM_W-1:0]  dim_clip;
    logic              lvl_range_ok;
    logic [LVL_W-1:0]  lvl_clip;
    logic [WORD_W-1:0] flags_expect;
    logic [WORD_W-1:0] caps_expect;
    logic              size_ok;

    assign hdr.ready = !job_full;
    assign accept    = hdr.valid && hdr.ready;
    assign first     = hdr.first_word;
    assign word      = hdr.header_word;
    assign eff_pos   = first ? '0 : pos_reg;
    assign active    = eff_pos < POS_DONE;

    assign dim_range_ok = (word != '0) && (word <= DIM_LIM);
    assign dim_clip     = (word > DIM_LIM) ? DIM_MAX : word[DIM_W-1:0];
    assign lvl_range_ok = (word != '0) && (word <= LVL_LIM);
    assign lvl_clip     = (word > LVL_LIM) ? LVL_MAX : word[LVL_W-1:0];
    assign flags_expect = FLAGS_BASE | ((lvl_clip > LVL_W'(1)) ? FLAGS_MIPMAP : '0);
    assign caps_expect  = CAPS_BASE | ((levels_next > LVL_W'(1)) ? CAPS_MIPMAP : '0);

    always_comb
    begin
        // Restart wipes the per-header state before this word is checked
        size_next     = first ? hdr.total_bytes : size_reg;
        width_next    = first ? '0 : width_reg;
        height_next   = first ? '0 : height_reg;
        levels_next   = first ? '0 : levels_reg;
        flags_next    = first ? '0 : flags_reg;
        word_ok       = (word == '0);
        unique case (eff_pos)
            POS_MAGIC:    word_ok = (word == DDS_MAGIC);
            POS_SIZE:     word_ok = (word == HDR_SIZE);
            POS_FLAGS:
            begin
                flags_next = word;
                word_ok    = 1'b1;
            end
            POS_HEIGHT:
            begin
                height_next = dim_clip;
                word_ok     = dim_range_ok;
            end
            POS_WIDTH:
            begin
                width_next = dim_clip;
                word_ok    = dim_range_ok;
            end
            POS_PITCH:    word_ok = (word == WORD_W'({width_next, 2'b00}));
            POS_MIPCOUNT:
            begin
                levels_next = lvl_clip;
                word_ok     = lvl_range_ok && (flags_next == flags_expect);
            end
            POS_PF_SIZE:  word_ok = (word == PF_SIZE);
            POS_PF_FLAGS: word_ok = (word == PF_FLAGS);
            POS_FOURCC:   word_ok = (word == DX10_TAG);
            POS_CAPS:     word_ok = (word == caps_expect);
            POS_DXGI_FMT: word_ok = (word == DXGI_FMT);
            POS_RES_DIM:  word_ok = (word == RES_DIM);
            POS_ARRAY_SZ: word_ok = (word == ARRAY_SZ);
            default:      word_ok = (word == '0);
        endcase
        mismatch_next = (!first && mismatch_reg) || (active && !word_ok);
        pos_next      = active ? eff_pos + POS_W'(1) : eff_pos;
    end

    assign size_ok  = (size_next >= MIN_FILE) && (size_next <= MAX_FILE);
    assign job_push = accept && (eff_pos == POS_LAST);
    assign job_data = {(!mismatch_next && size_ok), size_next, levels_next,
                       height_next, width_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            size_reg     <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            levels_reg   <= '0;
            flags_reg    <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            size_reg     <= size_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            levels_reg   <= levels_next;
            flags_reg    <= flags_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

>>> src/dhv_queue.sv
// dhv_queue: two-entry job queue between the front and back halves.
// Generic payload width; no package dependency.
// Lets word intake continue while the mip chain is summed.
module dhv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");
`endif

endmodule

>>> src/dhv_back.sv
// dhv_back: mip-chain summation and final size comparison.
// One mip level per cycle through a shared multiplier, then one compare.
// Depends on dhv_pkg and dhv_if.
module dhv_back import dhv_pkg::*; #(
    parameter int MAX_DIMENSION  = DEF_MAX_DIMENSION,
    parameter int MAX_MIP_LEVELS = DEF_MAX_MIP_LEVELS,
    parameter int DIM_W          = $clog2(MAX_DIMENSION + 1),
    parameter int LVL_W          = $clog2(MAX_MIP_LEVELS + 1),
    parameter int JOB_W          = 1 + SIZE_W + LVL_W + 2 * DIM_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_empty,
    input  logic [JOB_W-1:0] job_data,
    output logic             job_pop,
    dhv_out_if.source        result
);

    localparam int PROD_W = 2 * DIM_W;
    localparam int SUM_W  = 2 * DIM_W + 3;
    localparam int CMP_W  = (SUM_W + 1 > SIZE_W + 1) ? SUM_W + 1 : SIZE_W + 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [LVL_W-1:0]  lev_reg, lev_next;
    logic [LVL_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              prod_vld_reg, prod_vld_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              chain_ok_reg, chain_ok_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_bit_reg, out_bit_next;

    logic              job_ok;
    logic [SIZE_W-1:0] job_size;
    logic [LVL_W-1:0]  job_lev;
    logic [DIM_W-1:0]  job_h;
    logic [DIM_W-1:0]  job_w;
    logic              issue;
    logic              size_match;

    assign {job_ok, job_size, job_lev, job_h, job_w} = job_data;

    assign result.valid        = out_vld_reg;
    assign result.header_valid = out_bit_reg;

    assign job_pop    = (state_reg == B_IDLE) && !job_empty && !out_vld_reg;
    assign issue      = (cnt_reg < lev_reg);
    assign size_match = (CMP_W'(sum_reg) + CMP_W'(HEADER_BYTES)) == CMP_W'(size_reg);

    always_comb
    begin
        state_next    = state_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        lev_next      = lev_reg;
        cnt_next      = cnt_reg;
        size_next     = size_reg;
        prod_next     = prod_reg;
        prod_vld_next = prod_vld_reg;
        sum_next      = sum_reg;
        chain_ok_next = chain_ok_reg;
        out_vld_next  = (out_vld_reg && !result.ready);
        out_bit_next  = out_bit_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_pop)
                begin
                    if (job_ok)
                    begin
                        w_next        = job_w;
                        h_next        = job_h;
                        lev_next      = job_lev;
                        size_next     = job_size;
                        cnt_next      = '0;
                        sum_next      = '0;
                        prod_vld_next = 1'b0;
                        chain_ok_next = 1'b1;
                        state_next    = B_RUN;
                    end
                    else
                    begin
                        // Header already failed: skip the chain
                        out_vld_next = 1'b1;
                        out_bit_next = 1'b0;
                    end
                end
            end
            B_RUN:
            begin
                // Accumulate the product issued last cycle
                sum_next = sum_reg + (prod_vld_reg ? SUM_W'({prod_reg, 2'b00}) : '0);
                if (issue)
                begin
                    prod_next     = w_reg * h_reg;
                    prod_vld_next = 1'b1;
                    if ((LVL_W'(cnt_reg + LVL_W'(1)) < lev_reg) &&
                        (w_reg == DIM_W'(1)) && (h_reg == DIM_W'(1)))
                    begin
                        chain_ok_next = 1'b0;
                    end
                    w_next   = (w_reg > DIM_W'(1)) ? (w_reg >> 1) : DIM_W'(1);
                    h_next   = (h_reg > DIM_W'(1)) ? (h_reg >> 1) : DIM_W'(1);
                    cnt_next = cnt_reg + LVL_W'(1);
                end
                else
                begin
                    prod_vld_next = 1'b0;
                    if (!prod_vld_reg)
                    begin
                        state_next = B_DONE;
                    end
                end
            end
            B_DONE:
            begin
                out_vld_next = 1'b1;
                out_bit_next = chain_ok_reg && size_match;
                state_next   = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        h_reg        <= h_next;
        lev_reg      <= lev_next;
        cnt_reg      <= cnt_next;
        size_reg     <= size_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        chain_ok_reg <= chain_ok_next;
        out_bit_reg  <= out_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= prod_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

`ifndef SYNTHESIS
    a_done_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DONE) |-> (!prod_vld_reg && (cnt_reg == lev_reg)))
        else $error("verdict taken before the mip sum is complete");
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DONE) |-> !out_vld_reg)
        else $error("verdict would overwrite a pending result");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RUN) |-> (cnt_reg <= lev_reg))
        else $error("mip level counter ran past the level count");
`endif

endmodule
